// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define CHECK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHECK_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/kda_pkg.sv =====
// ----------------------------------------------------------------------------
// kda_pkg
// Codes, widths and register defaults for the key debounce block.
// ----------------------------------------------------------------------------
package kda_pkg;

  localparam int KEY_COUNT_DEF  = 16;
  localparam int FILTER_LEN_DEF = 4;

  localparam int MODE_W  = 2;
  localparam int KEY_W   = 4;
  localparam int EVENT_W = 3;
  localparam int PHASE_W = 4;
  localparam int TICK_W  = 8;
  localparam int PCNT_W  = 2;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KILL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_FIRST  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_LONG   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_REPEAT = 3'd3;
  localparam logic [EVENT_W-1:0] EV_BREAK  = 3'd4;

  // Key phases; the repeat phases run from every 16 ticks down to every tick
  localparam logic [PHASE_W-1:0] PH_OFF    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_START  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DELAY  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_R16    = 4'd3;
  localparam logic [PHASE_W-1:0] PH_R8     = 4'd4;
  localparam logic [PHASE_W-1:0] PH_R4     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_R2     = 4'd6;
  localparam logic [PHASE_W-1:0] PH_R1     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_PAUSE  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_KILLED = 4'd9;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_LONG_PRESS   = 3'd0;
  localparam logic [2:0] REG_REPEAT_DELAY = 3'd1;
  localparam logic [2:0] REG_ACCEL_PERIOD = 3'd2;
  localparam logic [2:0] REG_PAUSE        = 3'd3;
  localparam logic [2:0] REG_DOUBLE_WIN   = 3'd4;

  // Register reset values
  localparam logic [TICK_W-1:0] LONG_PRESS_RST   = 8'd24;
  localparam logic [TICK_W-1:0] REPEAT_DELAY_RST = 8'd40;
  localparam logic [TICK_W-1:0] ACCEL_PERIOD_RST = 8'd48;
  localparam logic [TICK_W-1:0] PAUSE_RST        = 8'd64;
  localparam logic [TICK_W-1:0] DOUBLE_WIN_RST   = 8'd16;

endpackage

// ===== rtl/key_debounce_autorepeat.sv =====
// ----------------------------------------------------------------------------
// key_debounce_autorepeat
// Debounce and auto-repeat for a bank of keys, one request per key update.
// ----------------------------------------------------------------------------
// Each request names a key and either ticks it with a raw sample, pauses it,
// kills it or just queries it; every request returns exactly one result with
// the event (none, first, long, repeat, break), the key, its debounced level
// and its double-press count. The block takes one request per clock as long
// as the result side is not stalled, and it registers the result: first the
// request lands in an input register, held while the result stalls, then the
// per-key state (filter, tick counter, phase, press count, all held in
// flip-flops and cleared by reset) is read, updated and written back in the
// same cycle that loads the result register. That single read-modify-write
// stage sets the rate; back-to-back requests to the same key see each
// other's updates with no stall. A stalled result holds the input register
// but a new request is still taken whenever the input register frees up.
// Configuration goes through a small APB port with five 8-bit timing
// registers at byte addresses 0, 4, 8, 12 and 16; write them only while no
// request is in flight.
`include "assert_macros.svh"

module key_debounce_autorepeat
  import kda_pkg::*;
#(
  parameter int KEY_COUNT  = KEY_COUNT_DEF,
  parameter int FILTER_LEN = FILTER_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [KEY_W-1:0]     in_key_index,
  input  logic                 in_sample,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [EVENT_W-1:0]   out_event_kind,
  output logic [KEY_W-1:0]     out_event_key,
  output logic                 out_pressed,
  output logic [PCNT_W-1:0]    out_double_count,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  // Index width into the key arrays, and a common width to fit the key field
  localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int EXT_W = (IDX_W > KEY_W) ? IDX_W : KEY_W;
  localparam logic [FILTER_LEN-1:0] FULL_MASK = '1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TICK_W-1:0] long_press_r, repeat_delay_r, accel_period_r;
  logic [TICK_W-1:0] pause_r, double_win_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= LONG_PRESS_RST;
      repeat_delay_r <= REPEAT_DELAY_RST;
      accel_period_r <= ACCEL_PERIOD_RST;
      pause_r        <= PAUSE_RST;
      double_win_r   <= DOUBLE_WIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LONG_PRESS:   long_press_r   <= pwdata[TICK_W-1:0];
        REG_REPEAT_DELAY: repeat_delay_r <= pwdata[TICK_W-1:0];
        REG_ACCEL_PERIOD: accel_period_r <= pwdata[TICK_W-1:0];
        REG_PAUSE:        pause_r        <= pwdata[TICK_W-1:0];
        REG_DOUBLE_WIN:   double_win_r   <= pwdata[TICK_W-1:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LONG_PRESS:   prdata = APB_DW'(long_press_r);
      REG_REPEAT_DELAY: prdata = APB_DW'(repeat_delay_r);
      REG_ACCEL_PERIOD: prdata = APB_DW'(accel_period_r);
      REG_PAUSE:        prdata = APB_DW'(pause_r);
      REG_DOUBLE_WIN:   prdata = APB_DW'(double_win_r);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              req_vld_r;
  logic [MODE_W-1:0] req_mode_r;
  logic [KEY_W-1:0]  req_key_r;
  logic              req_smp_r;
  logic              out_vld_r;
  logic              advance;
  logic              in_take;

  // Move the held request into the result register when that frees up
  assign advance  = req_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !req_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_take) begin
      req_vld_r <= 1'b1;
    end else if (advance) begin
      req_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_mode_r <= in_mode;
      req_key_r  <= in_key_index;
      req_smp_r  <= in_sample;
    end
  end

  // --------------------------------------------------------------------------
  // Per-key state
  // --------------------------------------------------------------------------
  logic [FILTER_LEN-1:0] filter_r [KEY_COUNT];
  logic [TICK_W-1:0]     tick_r   [KEY_COUNT];
  logic [PHASE_W-1:0]    phase_r  [KEY_COUNT];
  logic [PCNT_W-1:0]     pcnt_r   [KEY_COUNT];

  logic [EXT_W-1:0]      key_ext;
  logic [IDX_W-1:0]      key_idx;
  logic                  in_range;

  assign key_ext  = EXT_W'(req_key_r);
  assign key_idx  = key_ext[IDX_W-1:0];
  assign in_range = (32'(req_key_r) < KEY_COUNT);

  // --------------------------------------------------------------------------
  // Key update: one read-modify-write of the addressed key
  // --------------------------------------------------------------------------
  logic [FILTER_LEN-1:0] filter_nxt;
  logic [TICK_W-1:0]     tick_nxt;
  logic [PHASE_W-1:0]    phase_nxt;
  logic [PCNT_W-1:0]     pcnt_nxt;
  logic [EVENT_W-1:0]    ev_nxt;
  logic [TICK_W-1:0]     period_mask;

  always_comb begin
    filter_nxt  = filter_r[key_idx];
    tick_nxt    = tick_r[key_idx];
    phase_nxt   = phase_r[key_idx];
    pcnt_nxt    = pcnt_r[key_idx];
    ev_nxt      = EV_NONE;
    period_mask = '0;

    unique case (req_mode_r)
      MODE_TICK: begin
        // Shift the sample into the filter and advance the tick counter
        filter_nxt = FILTER_LEN'({filter_nxt, req_smp_r});
        tick_nxt   = tick_nxt + TICK_W'(1);

        // Filter all zeros ends any press; a killed press ends silently
        if (phase_nxt != PH_OFF && filter_nxt == '0) begin
          if (phase_nxt != PH_KILLED) begin
            ev_nxt = EV_BREAK;
            if (!(phase_nxt == PH_R16 && tick_nxt < double_win_r)) begin
              pcnt_nxt = '0;
            end
          end
          tick_nxt  = '0;
          phase_nxt = PH_OFF;
        end

        unique case (phase_nxt)
          PH_OFF: begin
            if (filter_nxt == FULL_MASK) begin
              phase_nxt = PH_START;
              if (tick_nxt > double_win_r) begin
                pcnt_nxt = '0;
              end
              tick_nxt = '0;
            end
          end
          PH_START: begin
            ev_nxt    = EV_FIRST;
            pcnt_nxt  = pcnt_nxt + PCNT_W'(1);
            phase_nxt = PH_DELAY;
            tick_nxt  = '0;
          end
          PH_DELAY: begin
            if (tick_nxt == long_press_r) begin
              ev_nxt = EV_LONG;
            end
            if (tick_nxt == repeat_delay_r) begin
              phase_nxt = PH_R16;
              tick_nxt  = '0;
            end
          end
          PH_R16, PH_R8, PH_R4, PH_R2, PH_R1: begin
            // Double the repeat rate after each acceleration period
            if (phase_nxt != PH_R1 && tick_nxt >= accel_period_r) begin
              phase_nxt = phase_nxt + PHASE_W'(1);
              tick_nxt  = '0;
            end
            unique case (phase_nxt)
              PH_R16:  period_mask = 8'd15;
              PH_R8:   period_mask = 8'd7;
              PH_R4:   period_mask = 8'd3;
              PH_R2:   period_mask = 8'd1;
              default: period_mask = 8'd0;
            endcase
            if ((tick_nxt & period_mask) == '0) begin
              ev_nxt = EV_REPEAT;
            end
          end
          PH_PAUSE: begin
            // Resume repeating at every eight ticks after the hold
            if (tick_nxt >= pause_r) begin
              phase_nxt = PH_R8;
              tick_nxt  = '0;
            end
          end
          default: ;  // killed: wait for release
        endcase
      end
      MODE_PAUSE: begin
        phase_nxt = PH_PAUSE;
        tick_nxt  = '0;
      end
      MODE_KILL: begin
        phase_nxt = PH_KILLED;
        pcnt_nxt  = '0;
      end
      MODE_QUERY: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        filter_r[i] <= '0;
        tick_r[i]   <= '0;
        phase_r[i]  <= PH_OFF;
        pcnt_r[i]   <= '0;
      end
    end else if (advance && in_range) begin
      filter_r[key_idx] <= filter_nxt;
      tick_r[key_idx]   <= tick_nxt;
      phase_r[key_idx]  <= phase_nxt;
      pcnt_r[key_idx]   <= pcnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [EVENT_W-1:0] ev_r;
  logic [KEY_W-1:0]   ev_key_r;
  logic               pressed_r;
  logic [PCNT_W-1:0]  dcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_key_r <= req_key_r;
      if (in_range) begin
        ev_r      <= ev_nxt;
        pressed_r <= (filter_nxt == FULL_MASK);
        dcnt_r    <= pcnt_nxt;
      end else begin
        // Keys past the bank report nothing
        ev_r      <= EV_NONE;
        pressed_r <= 1'b0;
        dcnt_r    <= '0;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_kind   = ev_r;
  assign out_event_key    = ev_key_r;
  assign out_pressed      = pressed_r;
  assign out_double_count = dcnt_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CHECK_NEXT(a_out_of_range_quiet, clk, rst_n, advance && !in_range,
    out_valid && out_event_kind == EV_NONE && !out_pressed && out_double_count == '0,
    "out-of-range key produced a non-empty result")
  `CHECK_NEXT(a_command_no_event, clk, rst_n, advance && req_mode_r != MODE_TICK,
    out_valid && out_event_kind == EV_NONE,
    "command or query produced an event")
  `CHECK_IMPL(a_no_overwrite, clk, rst_n, req_vld_r && out_vld_r && !out_ready,
    !in_ready && !advance,
    "held request would be overwritten or moved into a stalled result")
  `CHECK_IMPL(a_break_released, clk, rst_n, out_valid && out_event_kind == EV_BREAK,
    !out_pressed,
    "break event reported with key still pressed")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key debounce and auto-repeat block.
// ----------------------------------------------------------------------------
// Drives requests (tick with sample, pause, kill, query) into the block and
// predicts every result from a private copy of the per-key state and timing
// registers. It starts with a short directed sequence and then plays random
// press bursts: bounce in, a held stretch with glitches and pause and kill
// commands mixed in, then bounce out. Some bursts repeat quickly on the same
// key to build double-press counts. The five timing registers are
// reprogrammed between phases, with the extremes among the settings. Both
// channels idle at random, and the result side holds off once for a long
// stretch so the block backs up.

module testbench;
  import kda_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  localparam int LATENCY = 2;
  localparam int DRAIN_LIMIT = 2000;
  localparam int LONG_HOLD = 64;
  localparam int PHASE_ITEMS = 290;
  localparam int RUN_LIMIT = 6_000_000;

  typedef struct packed {
    logic [EVENT_W-1:0] kind;
    logic [KEY_W-1:0]   key;
    logic               pressed;
    logic [PCNT_W-1:0]  dcount;
  } key_report_t;

  // Holds its own per-key state and timing registers and predicts the result
  // of every accepted request; results are checked in order against it.
  class key_event_board;
    logic [FILTER_LEN_DEF-1:0] filt [KEY_COUNT_DEF];
    logic [TICK_W-1:0]         ticks [KEY_COUNT_DEF];
    logic [PHASE_W-1:0]        phase [KEY_COUNT_DEF];
    logic [PCNT_W-1:0]         presses [KEY_COUNT_DEF];
    logic [TICK_W-1:0]         long_press, repeat_delay, accel_period;
    logic [TICK_W-1:0]         pause_len, double_win;
    key_report_t               pending_reports[$];
    int                        errors;
    int                        checked;
    int                        event_seen[5];
    int                        fast_repeats;

    function new();
      for (int k = 0; k < KEY_COUNT_DEF; k++) begin
        filt[k] = '0;
        ticks[k] = '0;
        phase[k] = PH_OFF;
        presses[k] = '0;
      end
      long_press = LONG_PRESS_RST;
      repeat_delay = REPEAT_DELAY_RST;
      accel_period = ACCEL_PERIOD_RST;
      pause_len = PAUSE_RST;
      double_win = DOUBLE_WIN_RST;
      errors = 0;
      checked = 0;
      fast_repeats = 0;
      for (int i = 0; i < 5; i++) event_seen[i] = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [TICK_W-1:0] value);
      case (idx)
        REG_LONG_PRESS:   long_press = value;
        REG_REPEAT_DELAY: repeat_delay = value;
        REG_ACCEL_PERIOD: accel_period = value;
        REG_PAUSE:        pause_len = value;
        REG_DOUBLE_WIN:   double_win = value;
        default: ;
      endcase
    endfunction

    // One tick of one key: shift the filter, count, then walk the phases.
    function logic [EVENT_W-1:0] advance_key(int k, logic smp);
      logic [EVENT_W-1:0] ev;
      logic [PHASE_W-1:0] ph;
      logic [TICK_W-1:0]  period_mask;
      ev = EV_NONE;
      ph = phase[k];
      filt[k] = {filt[k][FILTER_LEN_DEF-2:0], smp};
      ticks[k] = ticks[k] + 8'd1;

      if (ph != PH_OFF && filt[k] == '0) begin
        if (ph != PH_KILLED) begin
          ev = EV_BREAK;
          if (!(ph == PH_R16 && ticks[k] < double_win)) presses[k] = '0;
        end
        ticks[k] = '0;
        ph = PH_OFF;
      end

      if (ph == PH_OFF) begin
        if (&filt[k]) begin
          ph = PH_START;
          if (ticks[k] > double_win) presses[k] = '0;
          ticks[k] = '0;
        end
      end else if (ph == PH_START) begin
        ev = EV_FIRST;
        presses[k] = presses[k] + 2'd1;
        ph = PH_DELAY;
        ticks[k] = '0;
      end else if (ph == PH_DELAY) begin
        if (ticks[k] == long_press) ev = EV_LONG;
        if (ticks[k] == repeat_delay) begin
          ph = PH_R16;
          ticks[k] = '0;
        end
      end else if (ph >= PH_R16 && ph <= PH_R1) begin
        if (ph != PH_R1 && ticks[k] >= accel_period) begin
          ph = ph + 4'd1;
          ticks[k] = '0;
        end
        period_mask = (8'd1 << (int'(PH_R1) - int'(ph))) - 8'd1;
        if ((ticks[k] & period_mask) == '0) begin
          ev = EV_REPEAT;
          if (ph == PH_R1) fast_repeats++;
        end
      end else if (ph == PH_PAUSE) begin
        if (ticks[k] >= pause_len) begin
          ph = PH_R8;
          ticks[k] = '0;
        end
      end

      phase[k] = ph;
      return ev;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic smp);
      key_report_t r;
      int          k;
      k = key;
      r.kind = EV_NONE;
      r.key = key;
      case (mode)
        MODE_TICK:  r.kind = advance_key(k, smp);
        MODE_PAUSE: begin
          phase[k] = PH_PAUSE;
          ticks[k] = '0;
        end
        MODE_KILL: begin
          phase[k] = PH_KILLED;
          presses[k] = '0;
        end
        default: ;
      endcase
      r.pressed = &filt[k];
      r.dcount = presses[k];
      event_seen[r.kind]++;
      pending_reports.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(key_report_t got);
      key_report_t want;
      checked++;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result for key %0d with no request outstanding",
                                  got.key));
        return;
      end
      want = pending_reports.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("key %0d: event %0d, expected %0d",
                                  want.key, got.kind, want.kind));
      if (got.key !== want.key)
        report_mismatch($sformatf("event key %0d, expected %0d", got.key, want.key));
      if (got.pressed !== want.pressed)
        report_mismatch($sformatf("key %0d: pressed %0b, expected %0b",
                                  want.key, got.pressed, want.pressed));
      if (got.dcount !== want.dcount)
        report_mismatch($sformatf("key %0d: double count %0d, expected %0d",
                                  want.key, got.dcount, want.dcount));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode = MODE_QUERY;
  logic [KEY_W-1:0]    in_key_index = '0;
  logic                in_sample = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [EVENT_W-1:0]  out_event_kind;
  logic [KEY_W-1:0]    out_event_key;
  logic                out_pressed;
  logic [PCNT_W-1:0]   out_double_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  key_event_board board;
  key_report_t    observed;
  int             sent_count = 0;
  bit             tx_idle_on = 1'b0;
  bit             rx_idle_on = 1'b0;
  bit             hold_off_req = 1'b0;

  key_debounce_autorepeat uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_key_index     (in_key_index),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_event_key    (out_event_key),
    .out_pressed      (out_pressed),
    .out_double_count (out_double_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Sample both handshakes on the edge itself: note the request first so a
  // prediction always exists before its result can show up.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_request(in_mode, in_key_index, in_sample);
    if (rst_n && out_valid && out_ready) begin
      observed.kind = out_event_kind;
      observed.key = out_event_key;
      observed.pressed = out_pressed;
      observed.dcount = out_double_count;
      board.check_result(observed);
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: one assignment to out_ready per pass, then at least one edge.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        // Hold off long enough for the block to fill and drop in_ready.
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
        stall = pick_gap();
        if (stall == 0) stall = 1;
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted; valid stays high into the
  // next request unless a gap is drawn.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                              logic smp);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key_index <= key;
    in_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic tick_key(logic [KEY_W-1:0] key, logic smp, int n);
    repeat (n) send_request(MODE_TICK, key, smp);
  endtask

  // Drop valid and wait out every outstanding result, then the pipeline.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the bus stays selected across a series
  // of writes and is released by the caller.
  task automatic reg_write(logic [2:0] idx, logic [TICK_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(APB_DW - TICK_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_register(idx, value);
  endtask

  task automatic program_timing(logic [TICK_W-1:0] lp, logic [TICK_W-1:0] rd,
                                logic [TICK_W-1:0] ap, logic [TICK_W-1:0] pt,
                                logic [TICK_W-1:0] dw);
    reg_write(REG_LONG_PRESS, lp);
    reg_write(REG_REPEAT_DELAY, rd);
    reg_write(REG_ACCEL_PERIOD, ap);
    reg_write(REG_PAUSE, pt);
    reg_write(REG_DOUBLE_WIN, dw);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Short walk through every mode and the named corner cases. Timing is set
  // with long press equal to repeat delay so only the long event fires then.
  task automatic run_directed();
    send_request(MODE_QUERY, 4'd15, 1'b0);
    tick_key(4'd0, 1'b1, 4);                // filter fills: press seen
    tick_key(4'd0, 1'b1, 3);                // first, then long at repeat start
    send_request(MODE_PAUSE, 4'd0, 1'b1);
    tick_key(4'd0, 1'b1, 2);                // pause runs out, resume at rate 8
    send_request(MODE_KILL, 4'd0, 1'b0);
    tick_key(4'd0, 1'b0, 4);                // killed key releases silently
    tick_key(4'd15, 1'b1, 7);               // press, first, enter repeat
    tick_key(4'd15, 1'b0, 4);               // release early: count is kept
    tick_key(4'd15, 1'b1, 5);               // quick second press: double
    send_request(MODE_QUERY, 4'd15, 1'b1);
  endtask

  // Ticks while a key is held: mostly level high, with glitches, commands
  // and requests to other keys mixed in.
  task automatic hold_tick(logic [KEY_W-1:0] key);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) send_request(MODE_PAUSE, key, 1'($urandom_range(0, 1)));
    else if (r < 6) send_request(MODE_KILL, key, 1'($urandom_range(0, 1)));
    else if (r < 10) send_request(MODE_QUERY, key, 1'($urandom_range(0, 1)));
    else if (r < 20)
      send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
    else if (r < 26) send_request(MODE_TICK, key, 1'b0);
    else send_request(MODE_TICK, key, 1'b1);
  endtask

  // Hold length drawn against the current timing so long, repeat and, within
  // the caps, every repeat rate are reached, plus releases aimed at the double window.
  function automatic int pick_hold();
    int lp, rd, dw, deep, lo, hi, r;
    lp = board.long_press;
    rd = board.repeat_delay;
    dw = board.double_win;
    deep = rd + 5 * int'(board.accel_period) + 8;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, lp + 2);
    if (r < 65) begin
      lo = rd;
      hi = rd + dw;
      if (hi > 300) hi = 300;
      if (lo > hi) lo = hi;
      return $urandom_range(lo, hi);
    end
    if (r < 95) return $urandom_range(0, (deep < 120) ? deep : 120);
    return $urandom_range(0, (deep < 400) ? deep : 400);
  endfunction

  task automatic press_burst(logic [KEY_W-1:0] key);
    int span;
    span = (board.double_win > 20) ? 20 : int'(board.double_win);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1) begin
      repeat ($urandom_range(0, 3)) send_request(MODE_TICK, key, 1'($urandom_range(0, 1)));
      tick_key(key, 1'b1, FILTER_LEN_DEF);
      repeat (pick_hold()) hold_tick(key);
      repeat ($urandom_range(0, 3)) send_request(MODE_TICK, key, 1'($urandom_range(0, 1)));
      tick_key(key, 1'b0, FILTER_LEN_DEF);
      tick_key(key, 1'b0, $urandom_range(0, span + 3));
    end
  endtask

  task automatic run_random(int budget);
    int stop;
    stop = sent_count + budget;
    while (sent_count < stop) begin
      // Idle per burst, so stretches with no idling on either side occur.
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        press_burst(4'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    logic [TICK_W-1:0] lp_rand;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_timing(8'd2, 8'd2, 8'd4, 8'd2, 8'd255);
    run_directed();
    settle();

    // Short timings; stall the result side early so the block backs up.
    program_timing(8'd3, 8'd6, 8'd4, 8'd5, 8'd8);
    hold_off_req = 1'b1;
    run_random(PHASE_ITEMS);
    settle();

    program_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    run_random(PHASE_ITEMS);
    settle();

    program_timing(LONG_PRESS_RST, REPEAT_DELAY_RST, ACCEL_PERIOD_RST, PAUSE_RST,
                   DOUBLE_WIN_RST);
    run_random(PHASE_ITEMS);
    settle();

    program_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(PHASE_ITEMS);
    settle();

    // Random small timings; half the time long press equals repeat delay.
    lp_rand = 8'($urandom_range(1, 12));
    program_timing(lp_rand, ($urandom_range(0, 1) != 0) ? lp_rand : 8'($urandom_range(1, 16)),
                   8'($urandom_range(1, 10)), 8'($urandom_range(1, 12)),
                   8'($urandom_range(1, 24)));
    run_random(PHASE_ITEMS);
    settle();

    if (board.pending_reports.size() != 0)
      board.report_mismatch($sformatf("%0d requests never answered",
                                      board.pending_reports.size()));

    $display("ran %0d requests over six timing settings: first %0d, long %0d,",
             sent_count, board.event_seen[EV_FIRST], board.event_seen[EV_LONG]);
    $display("repeat %0d, break %0d, repeats at the fastest rate %0d, checked %0d, errors %0d",
             board.event_seen[EV_REPEAT], board.event_seen[EV_BREAK],
             board.fast_repeats, board.checked, board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("run stopped at the time limit with requests outstanding");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== key_debounce_autorepeat.f =====
+incdir+rtl
rtl/kda_pkg.sv
rtl/key_debounce_autorepeat.sv
tb/testbench.sv
